// ----- src/md5_pkg.sv -----
package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // queue entry between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } md5_item_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_ROUND,
      ST_SUM,
      ST_PAD,
      ST_EMIT
   } md5_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_s(input logic [5:0] i);
      logic [4:0] s;
      unique case ({i[5:4], i[1:0]})
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] round_g(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
         2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
         default: g = 4'(i[3:0] * 4'd7);
      endcase
      return g;
   endfunction

endpackage

// ----- src/md5_front.sv -----
module md5_front #(
   parameter int Depth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                req_tuser,
   output logic                q_valid,
   input  logic                q_ready,
   output md5_pkg::md5_item_type q_item
);

   localparam int AW = $clog2(Depth);

   md5_pkg::md5_item_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          push, pop;

   assign req_tready = (cnt_ff != (AW+1)'(Depth));
   assign push = req_tvalid && req_tready && (req_tuser || req_tlast);
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_ready;
   assign q_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{data_byte: req_tdata, has_byte: req_tuser,
                            end_of_message: req_tlast};
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + AW'(1);
         if (pop)  rd_ff <= (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

// ----- src/md5_back.sv -----
module md5_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  md5_pkg::md5_item_type q_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   md5_pkg::md5_state_type state_ff, state_in;
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] buf_ff [16];   // byte 4*i+k sits in bits 8*k+7:8*k of word i
   logic [5:0]  pos_ff;
   logic [63:0] cnt_ff;
   logic [5:0]  rnd_ff;
   logic        fin_ff;    // padding still to do after this compression
   logic        two_ff;    // next pad block is the zero and length block
   logic        last_ff;   // this compression is the length block
   logic [1:0]  widx_ff;

   logic [31:0] f, w, sum, rot;
   logic [3:0]  g;
   logic [4:0]  s;
   logic [63:0] bits;
   logic        len_fits;
   logic [31:0] pad_word [16];

   always_comb begin
      g = md5_pkg::round_g(rnd_ff);
      s = md5_pkg::round_s(rnd_ff);
      w = buf_ff[g];
      unique case (rnd_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + md5_pkg::round_k(rnd_ff) + w;
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
      bits = {cnt_ff[60:0], 3'b000};
      len_fits = two_ff || (pos_ff < 6'd56);
   end

   // pad block: 0x80 at fill position, zeros after, length in top 8 bytes if room
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         for (int k = 0; k < 4; k++) begin
            if (two_ff || 6'(4*i+k) > pos_ff) pad_word[4'(i)][8*k +: 8] = 8'h00;
            else if (6'(4*i+k) == pos_ff) pad_word[4'(i)][8*k +: 8] = 8'h80;
            else pad_word[4'(i)][8*k +: 8] = buf_ff[4'(i)][8*k +: 8];
         end
      end
      if (len_fits) begin
         pad_word[4'd14] = bits[31:0];
         pad_word[4'd15] = bits[63:32];
      end
   end

   assign q_ready = (state_ff == md5_pkg::ST_FILL);
   assign rsp_tvalid = (state_ff == md5_pkg::ST_EMIT);
   assign rsp_tdata  = h_ff[widx_ff];
   assign rsp_tuser  = widx_ff;
   assign rsp_tlast  = (widx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= md5_pkg::ST_FILL;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         md5_pkg::ST_FILL: begin
            if (q_valid) begin
               if (q_item.has_byte && pos_ff == 6'd63) state_in = md5_pkg::ST_ROUND;
               else if (q_item.end_of_message) state_in = md5_pkg::ST_PAD;
            end
         end
         md5_pkg::ST_ROUND: begin
            if (rnd_ff == 6'd63) state_in = md5_pkg::ST_SUM;
         end
         md5_pkg::ST_SUM: begin
            if (last_ff) state_in = md5_pkg::ST_EMIT;
            else if (fin_ff) state_in = md5_pkg::ST_PAD;
            else state_in = md5_pkg::ST_FILL;
         end
         md5_pkg::ST_PAD: state_in = md5_pkg::ST_ROUND;
         md5_pkg::ST_EMIT: begin
            if (rsp_tready && widx_ff == 2'd3) state_in = md5_pkg::ST_FILL;
         end
         default: state_in = md5_pkg::ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= md5_pkg::INIT_A;
         h_ff[1] <= md5_pkg::INIT_B;
         h_ff[2] <= md5_pkg::INIT_C;
         h_ff[3] <= md5_pkg::INIT_D;
         pos_ff <= '0;
         cnt_ff <= '0;
         rnd_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         last_ff <= 1'b0;
         widx_ff <= '0;
      end else begin
         unique case (state_ff)
            md5_pkg::ST_FILL: begin
               if (q_valid) begin
                  if (q_item.has_byte) begin
                     buf_ff[pos_ff[5:2]][{pos_ff[1:0], 3'b000} +: 8] <= q_item.data_byte;
                     pos_ff <= pos_ff + 6'd1;
                     cnt_ff <= cnt_ff + 64'd1;
                  end
                  fin_ff <= q_item.end_of_message;
                  two_ff <= 1'b0;
                  last_ff <= 1'b0;
                  a_ff <= h_ff[0]; b_ff <= h_ff[1];
                  c_ff <= h_ff[2]; d_ff <= h_ff[3];
                  rnd_ff <= '0;
               end
            end
            md5_pkg::ST_ROUND: begin
               a_ff <= d_ff;
               d_ff <= c_ff;
               c_ff <= b_ff;
               b_ff <= b_ff + rot;
               rnd_ff <= rnd_ff + 6'd1;
            end
            md5_pkg::ST_SUM: begin
               h_ff[0] <= h_ff[0] + a_ff;
               h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff;
               h_ff[3] <= h_ff[3] + d_ff;
            end
            md5_pkg::ST_PAD: begin
               for (int i = 0; i < 16; i++) buf_ff[4'(i)] <= pad_word[4'(i)];
               fin_ff <= !len_fits;
               two_ff <= !len_fits;
               last_ff <= len_fits;
               a_ff <= h_ff[0]; b_ff <= h_ff[1];
               c_ff <= h_ff[2]; d_ff <= h_ff[3];
               rnd_ff <= '0;
            end
            md5_pkg::ST_EMIT: begin
               if (rsp_tready) begin
                  widx_ff <= widx_ff + 2'd1;
                  if (widx_ff == 2'd3) begin
                     h_ff[0] <= md5_pkg::INIT_A;
                     h_ff[1] <= md5_pkg::INIT_B;
                     h_ff[2] <= md5_pkg::INIT_C;
                     h_ff[3] <= md5_pkg::INIT_D;
                     pos_ff <= '0;
                     cnt_ff <= '0;
                     last_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- src/md5_hash_engine_top.sv -----
// After the end-of-message item the core builds the pad block, runs the 64 rounds and the
// chaining add (twice when an extra pad block is needed), then emits the four digest words
// one per cycle while rsp_tready is high. Queue items are taken one per cycle while filling;
// a full block stops the core reading the queue for the 64 rounds and the chaining add.
// A 4-entry queue decouples the input from the core.
// Synchronous active-high reset loads the MD5 initial words and clears counts and queue.
module md5_hash_engine_top #(
   parameter int QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,
   input  logic        req_tuser,   // has_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [1:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast
);

   logic                  q_valid, q_ready;
   md5_pkg::md5_item_type q_item;

   md5_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast, .req_tuser,
      .q_valid, .q_ready, .q_item
   );

   md5_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

// ----- src/md5_checker.sv -----
module md5_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd3))) else $error("tlast mismatch");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)
      else $error("word order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser)) else $error("hold");

endmodule

bind md5_hash_engine_top md5_checker u_md5_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tlast
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1000000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
      logic       check_fixed;
      logic [31:0] fixed_a;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   md5_hash_engine_top dut (.*);

   always #6 clock = ~clock;

   logic [31:0] chain [4];
   logic [7:0]  block_bytes [64];
   int unsigned fill_pos;
   logic [63:0] msg_bytes;
   digest_beat_type digest_queue [$];
   logic [31:0] fixed_a_queue [$];
   int   errors = 0;
   int   cycles = 0;

   localparam logic [31:0] RoundK [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   localparam int RoundS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   task automatic digest_init();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      fill_pos = 0;
      msg_bytes = '0;
   endtask

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int g, grp, s;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
         grp = i / 16;
         case (grp)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
         endcase
         s = RoundS[grp * 4 + i % 4];
         sum = a + f + RoundK[i] + w[g];
         t = d; d = c; c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endtask

   task automatic predict_digest(input logic [7:0] data, input logic has, input logic eom);
      logic [63:0] bit_len;
      if (has) begin
         block_bytes[fill_pos] = data;
         msg_bytes++;
         fill_pos = (fill_pos + 1) % 64;
         if (fill_pos == 0) compress();
      end
      if (eom) begin
         block_bytes[fill_pos] = 8'h80;
         for (int i = fill_pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
         if (fill_pos >= 56) begin
            compress();
            for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
         end
         bit_len = msg_bytes << 3;
         for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[8*i +: 8];
         compress();
         for (int i = 0; i < 4; i++)
            digest_queue.push_back(digest_beat_type'{chain[i], 2'(i), i == 3});
         digest_init();
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_beat(input logic [7:0] data, input logic has, input logic eom);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= has;
      req_tlast <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(data, has, eom);
      @(negedge clock);
   endtask

   initial begin
      int stall;
      wait (!reset);
      forever begin
         @(negedge clock);
         stall = gap_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[md5_hash_engine_top] ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         digest_beat_type exp_beat;
         if (digest_queue.size() == 0) begin
            $error("unexpected digest beat %h", rsp_tdata);
            errors++;
         end else begin
            exp_beat = digest_queue.pop_front();
            if (rsp_tdata !== exp_beat.word) begin
               $error("digest_word expected %h actual %h", exp_beat.word, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== exp_beat.index) begin
               $error("word_index expected %0d actual %0d", exp_beat.index, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== exp_beat.last) begin
               $error("last_word expected %0d actual %0d", exp_beat.last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser == 2'd0 && fixed_a_queue.size() > 0) begin
               logic [31:0] fa;
               fa = fixed_a_queue.pop_front();
               if (fa != '0 && rsp_tdata !== fa) begin
                  $error("digest_word expected %h actual %h", fa, rsp_tdata);
                  errors++;
               end
            end
         end
      end
   end

   stim_row_type directed [10] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'hd98c1dd4},   // empty message
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},          // idle item
      '{8'h61, 1'b1, 1'b1, 1'b1, 32'hb975c10c},   // "a"
      '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b0, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0}
   };

   task automatic send_message(input int len, input int noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, (i == len - 1) ? 1'b1 : 1'b0);
      end
      if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int len, r;
      digest_init();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         if (directed[i].end_of_message)
            fixed_a_queue.push_back(directed[i].check_fixed ? directed[i].fixed_a : 32'h0);
         send_beat(directed[i].data_byte, directed[i].has_byte, directed[i].end_of_message);
      end
      // pad boundary lengths: 55, 56, 63, 64
      send_message(55, 0);
      send_message(56, 0);
      send_message(63, 0);
      send_message(64, 0);
      send_message(0, 0);
      for (int n = 0; n < 4; n++) begin
         r = $urandom_range(0, 9);
         if (r < 6) len = $urandom_range(0, 20);
         else if (r < 9) len = $urandom_range(50, 70);
         else len = $urandom_range(100, 130);
         send_message(len, 10);
      end
      req_tvalid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("[md5_hash_engine_top] OK");
      end else begin
         $display("[md5_hash_engine_top] ERROR");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
src/md5_pkg.sv
src/md5_front.sv
src/md5_back.sv
src/md5_hash_engine_top.sv
src/md5_checker.sv
tb/sv/tb_top.sv
